// File: hdl/crc16chk_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc16chk_pkg
// Shared types, constants and the byte-wide CRC-16/CCITT-FALSE update.
// ----------------------------------------------------------------------------
package crc16chk_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned LEN_W    = 16;
    localparam int unsigned CRC_W    = 16;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [CRC_W-1:0] CRC_INIT       = 16'hFFFF;
    localparam logic [LEN_W-1:0] MIN_FRAME_LEN  = 16'd4;
    localparam logic [LEN_W-1:0] COUNT_MAX      = 16'hFFFF;
    localparam logic [LEN_W-1:0] MIN_LEN_RESET  = 16'd8;
    localparam logic [BYTE_W-1:0] ID_RESET      = 8'h00;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_LENGTH = 2'd0,
        CFG_ID_FIRST   = 2'd1,
        CFG_ID_SECOND  = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_VALID     = 3'd0,
        ST_TOO_SMALL = 3'd1,
        ST_ID_ERROR  = 3'd2,
        ST_TOO_SHORT = 3'd3,
        ST_TOO_LONG  = 3'd4,
        ST_CRC_ERROR = 3'd5
    } status_t;

    typedef struct packed {
        logic [LEN_W-1:0]  min_length;
        logic [BYTE_W-1:0] id_first;
        logic [BYTE_W-1:0] id_second;
    } cfg_t;

    typedef struct packed {
        logic             done;
        status_t          status;
        logic [LEN_W-1:0] length;
    } result_t;

    // poly 0x1021, msb first, one byte per call
    function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] x;
        x = crc[15:8] ^ b;
        x = x ^ {4'h0, x[7:4]};
        return {crc[7:0], 8'h00} ^ {x[3:0], 12'h000} ^ {3'b000, x, 5'b00000}
               ^ {8'h00, x};
    endfunction

endpackage

// File: hdl/packet_crc16_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packet_crc16_checker
// Checks length, id bytes and trailing CRC-16/CCITT-FALSE of byte packets.
// ----------------------------------------------------------------------------
// output: status is registered and valid in the cycle after the marked last byte is accepted
// throughput: one byte per cycle; input stalls only while a status is held
//   by a stalled output register
// reset: packet state cleared, min_length = 8, id bytes = 0, no status pending
module packet_crc16_checker
    import crc16chk_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [BYTE_W-1:0]    data_byte,
    input  logic                 last_byte,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [2:0]           status,
    output logic [LEN_W-1:0]     received_length,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [LEN_W-1:0]     cfg_data
);

    cfg_t             cfg_reg;
    result_t          result;
    logic             byte_en;
    logic             out_valid_reg;
    status_t          status_reg;
    logic [LEN_W-1:0] length_reg;

    assign cfg_ready = 1'b1;
    assign in_stall  = out_valid_reg & out_stall;
    assign byte_en   = in_valid & ~in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_length <= MIN_LEN_RESET;
            cfg_reg.id_first   <= ID_RESET;
            cfg_reg.id_second  <= ID_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_MIN_LENGTH: cfg_reg.min_length <= cfg_data;
                CFG_ID_FIRST:   cfg_reg.id_first   <= cfg_data[BYTE_W-1:0];
                CFG_ID_SECOND:  cfg_reg.id_second  <= cfg_data[BYTE_W-1:0];
                default:        ;
            endcase
        end
    end

    crc16chk_frame u_frame (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_en   (byte_en),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .cfg       (cfg_reg),
        .result    (result)
    );

    // output register; a new status only lands when the slot is free or draining
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (result.done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result.done)
        begin
            status_reg <= result.status;
            length_reg <= result.length;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign received_length = length_reg;

endmodule

// File: hdl/crc16chk_frame.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc16chk_frame
// Per-packet state: byte count, id match, length field, running crc and the
// two-byte tail delay line. Produces the packet status on the marked byte.
// ----------------------------------------------------------------------------
module crc16chk_frame
    import crc16chk_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_en,
    input  logic [BYTE_W-1:0] data_byte,
    input  logic              last_byte,
    input  cfg_t              cfg,
    output result_t           result
);

    logic [LEN_W-1:0]  count_reg,    count_next;
    logic              ovf_reg,      ovf_next;
    logic [CRC_W-1:0]  crc_reg,      crc_next;
    logic [BYTE_W-1:0] tail0_reg,    tail0_next;
    logic [BYTE_W-1:0] tail1_reg,    tail1_next;
    logic [1:0]        id_match_reg, id_match_next;
    logic [LEN_W-1:0]  decl_reg,     decl_next;

    logic [LEN_W-1:0]  cnt_upd;
    logic              ovf_upd;
    logic [CRC_W-1:0]  crc_upd;
    logic [1:0]        id_upd;
    logic [LEN_W-1:0]  decl_upd;
    logic [CRC_W-1:0]  crc_sent;
    status_t           status;

    always_comb
    begin
        id_upd   = id_match_reg;
        decl_upd = decl_reg;
        case (count_reg)
            16'd0:   id_upd[0] = (data_byte == cfg.id_first);
            16'd1:   id_upd[1] = (data_byte == cfg.id_second);
            16'd2:   decl_upd[15:8] = data_byte;
            16'd3:   decl_upd[7:0]  = data_byte;
            default: ;
        endcase

        // crc runs over the byte leaving the delay line
        crc_upd = (|count_reg[LEN_W-1:1]) ? crc_feed(crc_reg, tail0_reg) : crc_reg;

        ovf_upd = ovf_reg | (count_reg == COUNT_MAX);
        cnt_upd = (count_reg == COUNT_MAX) ? count_reg : count_reg + 16'd1;

        crc_sent = {tail1_reg, data_byte};

        if (cnt_upd < MIN_FRAME_LEN || cnt_upd < cfg.min_length)
            status = ST_TOO_SMALL;
        else if (id_upd != 2'b11)
            status = ST_ID_ERROR;
        else if (!ovf_upd && decl_upd > cnt_upd)
            status = ST_TOO_SHORT;
        else if (ovf_upd || decl_upd < cnt_upd)
            status = ST_TOO_LONG;
        else if (crc_sent != crc_upd)
            status = ST_CRC_ERROR;
        else
            status = ST_VALID;

        result.done   = byte_en & last_byte;
        result.status = status;
        result.length = cnt_upd;

        count_next    = count_reg;
        ovf_next      = ovf_reg;
        crc_next      = crc_reg;
        tail0_next    = tail0_reg;
        tail1_next    = tail1_reg;
        id_match_next = id_match_reg;
        decl_next     = decl_reg;
        if (byte_en)
        begin
            if (last_byte)
            begin
                count_next    = '0;
                ovf_next      = 1'b0;
                crc_next      = CRC_INIT;
                tail0_next    = '0;
                tail1_next    = '0;
                id_match_next = '0;
                decl_next     = '0;
            end
            else
            begin
                count_next    = cnt_upd;
                ovf_next      = ovf_upd;
                crc_next      = crc_upd;
                tail0_next    = tail1_reg;
                tail1_next    = data_byte;
                id_match_next = id_upd;
                decl_next     = decl_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
            crc_reg      <= CRC_INIT;
            tail0_reg    <= '0;
            tail1_reg    <= '0;
            id_match_reg <= '0;
            decl_reg     <= '0;
        end
        else
        begin
            count_reg    <= count_next;
            ovf_reg      <= ovf_next;
            crc_reg      <= crc_next;
            tail0_reg    <= tail0_next;
            tail1_reg    <= tail1_next;
            id_match_reg <= id_match_next;
            decl_reg     <= decl_next;
        end
    end

endmodule

// File: verif/frame_status_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_status_monitor
// Watches the byte, status and register channels of packet_crc16_checker,
// tracks the packet state in parallel and compares every status returned.
// ----------------------------------------------------------------------------
module frame_status_monitor
    import crc16chk_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  logic [BYTE_W-1:0]    data_byte,
    input  logic                 last_byte,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  logic [2:0]           status,
    input  logic [LEN_W-1:0]     received_length,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [LEN_W-1:0]     cfg_data,
    output int                   mismatches,
    output int                   statuses_due
);

    typedef struct packed {
        status_t          code;
        logic [LEN_W-1:0] length;
    } frame_verdict_t;

    frame_verdict_t verdict_q[$];

    logic [LEN_W-1:0]  min_len;
    logic [BYTE_W-1:0] id_a;
    logic [BYTE_W-1:0] id_b;

    logic [LEN_W-1:0]  count;
    logic              overflow;
    logic [CRC_W-1:0]  crc_acc;
    logic [BYTE_W-1:0] tail_old;
    logic [BYTE_W-1:0] tail_new;
    logic [1:0]        id_hits;
    logic [LEN_W-1:0]  len_field;
    int                fail_total = 0;

    initial mismatches = 0;
    initial statuses_due = 0;

    // bit-serial form, msb first, poly 0x1021
    function automatic logic [CRC_W-1:0] crc_ccitt_byte(logic [CRC_W-1:0] crc,
                                                        logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc;
        for (int i = BYTE_W - 1; i >= 0; i--) begin
            if (c[15] ^ b[i])
                c = {c[14:0], 1'b0} ^ 16'h1021;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

    task automatic clear_frame();
        count     = '0;
        overflow  = 1'b0;
        crc_acc   = CRC_INIT;
        tail_old  = '0;
        tail_new  = '0;
        id_hits   = '0;
        len_field = '0;
    endtask

    task automatic predict_byte(logic [BYTE_W-1:0] b, logic last);
        frame_verdict_t   v;
        logic [CRC_W-1:0] crc_sent;
        if (count == 16'd0)
            id_hits[0] = (b == id_a);
        else if (count == 16'd1)
            id_hits[1] = (b == id_b);
        else if (count == 16'd2)
            len_field[15:8] = b;
        else if (count == 16'd3)
            len_field[7:0] = b;

        // the crc only sees a byte once it leaves the two-byte tail
        if (count >= 16'd2)
            crc_acc = crc_ccitt_byte(crc_acc, tail_old);

        if (count == COUNT_MAX)
            overflow = 1'b1;
        else
            count = count + 16'd1;

        if (!last) begin
            tail_old = tail_new;
            tail_new = b;
        end
        else begin
            crc_sent = {tail_new, b};
            v.length = count;
            if (count < MIN_FRAME_LEN || count < min_len)
                v.code = ST_TOO_SMALL;
            else if (id_hits != 2'b11)
                v.code = ST_ID_ERROR;
            else if (!overflow && len_field > count)
                v.code = ST_TOO_SHORT;
            else if (overflow || len_field < count)
                v.code = ST_TOO_LONG;
            else if (crc_sent != crc_acc)
                v.code = ST_CRC_ERROR;
            else
                v.code = ST_VALID;
            verdict_q.push_back(v);
            clear_frame();
        end
    endtask

    task automatic check_status();
        frame_verdict_t v;
        if (verdict_q.size() == 0) begin
            $error("status %0d length %0d returned with no packet pending",
                   status, received_length);
            fail_total++;
        end
        else begin
            v = verdict_q.pop_front();
            if (status !== v.code) begin
                $error("status: expected %0d, actual %0d", v.code, status);
                fail_total++;
            end
            if (received_length !== v.length) begin
                $error("received_length: expected %0d, actual %0d",
                       v.length, received_length);
                fail_total++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            min_len = MIN_LEN_RESET;
            id_a    = ID_RESET;
            id_b    = ID_RESET;
            clear_frame();
            verdict_q.delete();
            statuses_due <= 0;
        end
        else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_MIN_LENGTH: min_len = cfg_data;
                    CFG_ID_FIRST:   id_a = cfg_data[BYTE_W-1:0];
                    CFG_ID_SECOND:  id_b = cfg_data[BYTE_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                predict_byte(data_byte, last_byte);
            if (out_valid && !out_stall)
                check_status();
            statuses_due <= verdict_q.size();
            mismatches   <= fail_total;
        end
    end

endmodule

// File: verif/tb_packet_crc16_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_packet_crc16_checker
// Feeds packet_crc16_checker directed and random packets (good frames, bad
// ids, wrong length fields, crc damage, runts) under several register
// settings and idle/stall mixes; frame_status_monitor predicts and compares
// every status.
// ----------------------------------------------------------------------------
module tb_packet_crc16_checker;
    import crc16chk_pkg::*;

    localparam int QUIET_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 4;
    localparam int PHASE_BYTES   = 45;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic [BYTE_W-1:0]    data_byte = '0;
    logic                 last_byte = 1'b0;
    logic                 out_stall = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [LEN_W-1:0]     cfg_data  = '0;

    logic                 in_stall;
    logic                 out_valid;
    logic                 cfg_ready;
    logic [2:0]           status;
    logic [LEN_W-1:0]     received_length;

    int mismatches;
    int statuses_due;

    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    logic hold_off       = 1'b0;
    int   quiet_cycles   = 0;
    int   sent_bytes     = 0;

    logic [LEN_W-1:0]  cur_min  = MIN_LEN_RESET;
    logic [BYTE_W-1:0] cur_id_a = ID_RESET;
    logic [BYTE_W-1:0] cur_id_b = ID_RESET;
    logic [BYTE_W-1:0] frame[$];

    packet_crc16_checker u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .data_byte       (data_byte),
        .last_byte       (last_byte),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .received_length (received_length),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    frame_status_monitor u_monitor (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .data_byte       (data_byte),
        .last_byte       (last_byte),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .received_length (received_length),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatches      (mismatches),
        .statuses_due    (statuses_due)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        out_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL packet_crc16_checker");
            $finish;
        end
    end

    task automatic set_idling(int send_pct, int recv_pct);
        send_idle_pct = send_pct;
        recv_stall_pct <= recv_pct;
    endtask

    task automatic send_byte(logic [BYTE_W-1:0] b, logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        last_byte <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent_bytes++;
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame.size(); i++)
            send_byte(frame[i], i == frame.size() - 1);
    endtask

    // well-formed packet for the current ids; short ones get clobbered by the crc
    task automatic fill_frame(int len);
        logic [CRC_W-1:0] crc;
        frame.delete();
        for (int i = 0; i < len; i++)
            frame.push_back(8'($urandom));
        frame[0] = cur_id_a;
        if (len > 1)
            frame[1] = cur_id_b;
        if (len > 3) begin
            frame[2] = len[15:8];
            frame[3] = len[7:0];
        end
        crc = CRC_INIT;
        for (int i = 0; i < len - 2; i++)
            crc = crc_feed(crc, frame[i]);
        if (len > 1) begin
            frame[len-2] = crc[15:8];
            frame[len-1] = crc[7:0];
        end
    endtask

    // waits until every status is back and the block has gone quiet
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (statuses_due != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_config(logic [LEN_W-1:0] min_len, logic [BYTE_W-1:0] id_a,
                                logic [BYTE_W-1:0] id_b);
        cfg_idx_t         regs [3];
        logic [LEN_W-1:0] vals [3];
        regs = '{CFG_MIN_LENGTH, CFG_ID_FIRST, CFG_ID_SECOND};
        vals = '{min_len, {8'h00, id_a}, {8'h00, id_b}};
        for (int k = 0; k < 3; k++) begin
            cfg_valid <= 1'b1;
            cfg_index <= regs[k];
            cfg_data  <= vals[k];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
        end
        cfg_valid <= 1'b0;
        cur_min  = min_len;
        cur_id_a = id_a;
        cur_id_b = id_b;
    endtask

    task automatic random_frame();
        int               len;
        int               kind;
        int               pos;
        logic [LEN_W-1:0] claimed;
        if ($urandom_range(99) < 10)
            len = $urandom_range(1, 5);
        else if ($urandom_range(99) < 12 && cur_min <= 40)
            len = int'(cur_min) + $urandom_range(0, 2) - 1;
        else
            len = $urandom_range(6, 24);
        fill_frame(len);
        kind = $urandom_range(99);
        pos  = $urandom_range(len - 1);
        if (kind >= 65) begin
            if (kind < 72)
                frame[0] ^= 8'($urandom_range(1, 255));
            else if (kind < 78 && len > 1)
                frame[1] ^= 8'($urandom_range(1, 255));
            else if (kind < 86 && len > 3) begin
                // near misses on the length field
                claimed  = 16'(len + $urandom_range(0, 4) - 2);
                frame[2] = claimed[15:8];
                frame[3] = claimed[7:0];
            end
            else if (kind < 94)
                frame[pos] ^= 8'($urandom_range(1, 255));
            else
                foreach (frame[i])
                    frame[i] = 8'($urandom);
        end
        send_frame();
    endtask

    task automatic random_phase(int target);
        int start;
        start = sent_bytes;
        while (sent_bytes - start < target)
            random_frame();
    endtask

    task automatic hold_receiver();
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: min length 8, both ids zero
        fill_frame(10);
        send_frame();
        drain();

        write_config(16'd4, 8'hA5, 8'h5A);
        for (int n = 1; n <= 3; n++) begin
            fill_frame(n);
            send_frame();
        end
        fill_frame(4);
        send_frame();
        fill_frame(12);
        frame[0] ^= 8'h01;
        send_frame();
        fill_frame(12);
        frame[1] ^= 8'h80;
        send_frame();
        fill_frame(12);
        frame[0] = ~frame[0];
        frame[1] = ~frame[1];
        send_frame();
        fill_frame(9);
        frame[2] = 8'hFF;
        frame[3] = 8'hFF;
        send_frame();
        fill_frame(9);
        frame[2] = 8'h00;
        frame[3] = 8'h00;
        send_frame();
        fill_frame(9);
        frame[3] = 8'd10;
        send_frame();
        fill_frame(9);
        frame[3] = 8'd8;
        send_frame();
        fill_frame(16);
        frame[14] ^= 8'h01;
        send_frame();
        fill_frame(16);
        frame[15] ^= 8'h80;
        send_frame();
        fill_frame(6);
        send_frame();
        fill_frame(40);
        send_frame();
        drain();

        write_config(16'd20, 8'hFF, 8'h00);
        for (int n = 19; n <= 21; n++) begin
            fill_frame(n);
            send_frame();
        end
        drain();

        write_config(16'd8, 8'h00, 8'hFF);
        set_idling(0, 0);
        random_phase(PHASE_BYTES);
        drain();
        write_config(16'd4, 8'($urandom), 8'($urandom));
        set_idling(57, 0);
        random_phase(PHASE_BYTES);
        drain();
        write_config(16'($urandom_range(4, 16)), 8'($urandom), 8'($urandom));
        set_idling(0, 57);
        random_phase(PHASE_BYTES);
        drain();
        write_config(16'd6, 8'hFF, 8'hFF);
        set_idling(20, 20);
        random_phase(PHASE_BYTES);
        drain();

        // receiver holds off while packets keep coming, so the input backs up
        set_idling(0, 0);
        fork
            hold_receiver();
            repeat (8) random_frame();
        join
        drain();

        if (mismatches == 0)
            $display("PASS packet_crc16_checker");
        else
            $display("FAIL packet_crc16_checker");
        $finish;
    end

endmodule
